>>> rtl/delta_stream_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// Delta stream decoder assertion macros
// Shared concurrent assertion forms for the decoder modules.
// ----------------------------------------------------------------------------
`ifndef DELTA_STREAM_DECODER_CORE_ASSERT_SVH
`define DELTA_STREAM_DECODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSD_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("delta stream decoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define DSD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("delta stream decoder check failed");

`endif

>>> rtl/dsd_pkg.sv
// ----------------------------------------------------------------------------
// Delta stream decoder package
// Types and constants shared by the front parser, the queue and the back end.
// ----------------------------------------------------------------------------
package dsd_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [23:0] COPY_LEN_DEFAULT = 24'h010000;

    typedef enum logic [1:0] {
        KIND_BASE   = 2'd0,
        KIND_TARGET = 2'd1,
        KIND_COPY   = 2'd2,
        KIND_LIT    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_BASE   = 3'd0,
        PH_TARGET = 3'd1,
        PH_CMD    = 3'd2,
        PH_ARGS   = 3'd3,
        PH_INSERT = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_BASE   = 3'd1,
        OP_TARGET = 3'd2,
        OP_COPY   = 3'd3,
        OP_INSERT = 3'd4,
        OP_LIT    = 3'd5
    } op_code_t;

    // One classified operation handed from the front parser to the back end.
    typedef struct packed {
        op_code_t    code;
        logic [31:0] value;
        logic [23:0] len;
        logic        last;
    } op_t;

endpackage

>>> rtl/dsd_front.sv
// ----------------------------------------------------------------------------
// Delta stream decoder front parser
// Decodes the header varints and command bytes and issues each operation on the byte that completes it.
// ----------------------------------------------------------------------------
module dsd_front #(
    parameter int SIZE_WIDTH = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept_i,
    input  logic [7:0]    data_byte_i,
    input  logic          last_i,
    output logic          push_o,
    output dsd_pkg::op_t  op_o
);

    dsd_pkg::phase_t         phase_reg, phase_next;
    logic [5:0]              shift_pos_reg, shift_pos_next;
    logic [SIZE_WIDTH-1:0]   size_accum_reg, size_accum_next;
    logic [6:0]              arg_mask_reg, arg_mask_next;
    logic [31:0]             copy_offset_reg, copy_offset_next;
    logic [23:0]             copy_len_reg, copy_len_next;
    logic [6:0]              insert_left_reg, insert_left_next;

    logic [63:0]             group_shifted;
    logic [SIZE_WIDTH-1:0]   accum_upd;
    logic [63:0]             accum_ext;
    logic [6:0]              arg_sel;
    logic [6:0]              arg_mask_cleared;
    logic [31:0]             offset_upd;
    logic [23:0]             len_upd;
    logic [23:0]             copy_len_final;

    always_comb begin
        group_shifted = {57'd0, data_byte_i[6:0]} << shift_pos_reg;
        if ({1'b0, shift_pos_reg} < 7'(SIZE_WIDTH)) begin
            accum_upd = size_accum_reg | group_shifted[SIZE_WIDTH-1:0];
        end else begin
            accum_upd = size_accum_reg;
        end
        accum_ext = 64'(accum_upd);
    end

    always_comb begin
        arg_sel          = arg_mask_reg & (~arg_mask_reg + 7'd1);
        arg_mask_cleared = arg_mask_reg & ~arg_sel;
        offset_upd       = copy_offset_reg;
        len_upd          = copy_len_reg;
        for (int k = 0; k < 4; k++) begin
            if (arg_sel[k]) begin
                offset_upd[8*k +: 8] = offset_upd[8*k +: 8] | data_byte_i;
            end
        end
        for (int k = 0; k < 3; k++) begin
            if (arg_sel[4+k]) begin
                len_upd[8*k +: 8] = len_upd[8*k +: 8] | data_byte_i;
            end
        end
    end

    // A length field of zero stands for the default copy length.
    always_comb begin
        if (len_upd == 24'd0) begin
            copy_len_final = dsd_pkg::COPY_LEN_DEFAULT;
        end else begin
            copy_len_final = len_upd;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            dsd_pkg::PH_BASE: begin
                if (!data_byte_i[7]) begin
                    phase_next = dsd_pkg::PH_TARGET;
                end
            end
            dsd_pkg::PH_TARGET: begin
                if (!data_byte_i[7]) begin
                    phase_next = dsd_pkg::PH_CMD;
                end
            end
            dsd_pkg::PH_CMD: begin
                if (data_byte_i[7]) begin
                    if (data_byte_i[6:0] != 7'd0) begin
                        phase_next = dsd_pkg::PH_ARGS;
                    end
                end else if (data_byte_i[6:0] != 7'd0) begin
                    phase_next = dsd_pkg::PH_INSERT;
                end
            end
            dsd_pkg::PH_ARGS: begin
                if (arg_mask_cleared == 7'd0) begin
                    phase_next = dsd_pkg::PH_CMD;
                end
            end
            dsd_pkg::PH_INSERT: begin
                if (insert_left_reg <= 7'd1) begin
                    phase_next = dsd_pkg::PH_CMD;
                end
            end
            default: begin
                phase_next = dsd_pkg::PH_BASE;
            end
        endcase
        if (last_i) begin
            phase_next = dsd_pkg::PH_BASE;
        end
    end

    always_comb begin
        shift_pos_next   = shift_pos_reg;
        size_accum_next  = size_accum_reg;
        arg_mask_next    = arg_mask_reg;
        copy_offset_next = copy_offset_reg;
        copy_len_next    = copy_len_reg;
        insert_left_next = insert_left_reg;
        op_o.code        = dsd_pkg::OP_NONE;
        op_o.value       = 32'd0;
        op_o.len         = 24'd0;
        op_o.last        = last_i;
        unique case (phase_reg)
            dsd_pkg::PH_BASE, dsd_pkg::PH_TARGET: begin
                size_accum_next = accum_upd;
                shift_pos_next  = (shift_pos_reg >= 6'd57) ? 6'd63 : shift_pos_reg + 6'd7;
                if (!data_byte_i[7]) begin
                    op_o.code       = (phase_reg == dsd_pkg::PH_BASE) ?
                                      dsd_pkg::OP_BASE : dsd_pkg::OP_TARGET;
                    op_o.value      = accum_ext[31:0];
                    shift_pos_next  = 6'd0;
                    size_accum_next = '0;
                end
            end
            dsd_pkg::PH_CMD: begin
                if (data_byte_i[7]) begin
                    arg_mask_next    = data_byte_i[6:0];
                    copy_offset_next = 32'd0;
                    copy_len_next    = 24'd0;
                    if (data_byte_i[6:0] == 7'd0) begin
                        op_o.code = dsd_pkg::OP_COPY;
                        op_o.len  = dsd_pkg::COPY_LEN_DEFAULT;
                    end
                end else if (data_byte_i[6:0] != 7'd0) begin
                    insert_left_next = data_byte_i[6:0];
                    op_o.code        = dsd_pkg::OP_INSERT;
                    op_o.value       = {25'd0, data_byte_i[6:0]};
                end
            end
            dsd_pkg::PH_ARGS: begin
                arg_mask_next    = arg_mask_cleared;
                copy_offset_next = offset_upd;
                copy_len_next    = len_upd;
                if (arg_mask_cleared == 7'd0) begin
                    op_o.code  = dsd_pkg::OP_COPY;
                    op_o.value = offset_upd;
                    op_o.len   = copy_len_final;
                end
            end
            dsd_pkg::PH_INSERT: begin
                op_o.code  = dsd_pkg::OP_LIT;
                op_o.value = {24'd0, data_byte_i};
                if (insert_left_reg != 7'd0) begin
                    insert_left_next = insert_left_reg - 7'd1;
                end
            end
            default: begin
            end
        endcase
        if (last_i) begin
            shift_pos_next   = 6'd0;
            size_accum_next  = '0;
            arg_mask_next    = 7'd0;
            copy_offset_next = 32'd0;
            copy_len_next    = 24'd0;
            insert_left_next = 7'd0;
        end
    end

    assign push_o = accept_i && ((op_o.code != dsd_pkg::OP_NONE) || last_i);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= dsd_pkg::PH_BASE;
            shift_pos_reg   <= 6'd0;
            size_accum_reg  <= '0;
            arg_mask_reg    <= 7'd0;
            copy_offset_reg <= 32'd0;
            copy_len_reg    <= 24'd0;
            insert_left_reg <= 7'd0;
        end else if (accept_i) begin
            phase_reg       <= phase_next;
            shift_pos_reg   <= shift_pos_next;
            size_accum_reg  <= size_accum_next;
            arg_mask_reg    <= arg_mask_next;
            copy_offset_reg <= copy_offset_next;
            copy_len_reg    <= copy_len_next;
            insert_left_reg <= insert_left_next;
        end
    end

endmodule

>>> rtl/dsd_queue.sv
// ----------------------------------------------------------------------------
// Delta stream decoder operation queue
// A short first-in first-out buffer between the front parser and the back end.
// ----------------------------------------------------------------------------
module dsd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_i,
    input  dsd_pkg::op_t  op_i,
    input  logic          pop_i,
    output logic          full_o,
    output logic          empty_o,
    output dsd_pkg::op_t  head_o
);

    dsd_pkg::op_t                 entry_reg [dsd_pkg::QUEUE_DEPTH];
    logic [dsd_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [dsd_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [dsd_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                         do_push;
    logic                         do_pop;

    assign full_o  = (count_reg == dsd_pkg::QCNT_W'(dsd_pkg::QUEUE_DEPTH));
    assign empty_o = (count_reg == '0);
    assign head_o  = entry_reg[rd_ptr_reg];
    assign do_push = push_i && !full_o;
    assign do_pop  = pop_i && !empty_o;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= op_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/dsd_back.sv
// ----------------------------------------------------------------------------
// Delta stream decoder back end
// Tracks the target bytes still owed, clamps copies and literals, and drives results.
// ----------------------------------------------------------------------------
`include "delta_stream_decoder_core_assert.svh"

module dsd_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          empty_i,
    input  dsd_pkg::op_t  head_i,
    output logic          pop_o,
    output logic          m_valid_o,
    input  logic          m_ready_i,
    output logic [1:0]    kind_o,
    output logic [31:0]   value_o,
    output logic [23:0]   length_o
);

    logic [31:0]      target_left_reg, target_left_next;
    logic [6:0]       emit_left_reg, emit_left_next;
    logic             m_valid_reg, m_valid_next;
    dsd_pkg::kind_t   kind_reg, kind_next;
    logic [31:0]      value_reg, value_next;
    logic [23:0]      length_reg, length_next;

    logic             out_free;
    logic             produce;
    logic [23:0]      copy_clamped;
    logic [6:0]       emit_clamped;

    assign out_free = !m_valid_reg || m_ready_i;
    assign pop_o    = !empty_i && out_free;

    always_comb begin
        if (target_left_reg < {8'd0, head_i.len}) begin
            copy_clamped = target_left_reg[23:0];
        end else begin
            copy_clamped = head_i.len;
        end
        if (target_left_reg < {25'd0, head_i.value[6:0]}) begin
            emit_clamped = target_left_reg[6:0];
        end else begin
            emit_clamped = head_i.value[6:0];
        end
    end

    always_comb begin
        target_left_next = target_left_reg;
        emit_left_next   = emit_left_reg;
        produce          = 1'b0;
        kind_next        = kind_reg;
        value_next       = value_reg;
        length_next      = length_reg;
        if (pop_o) begin
            unique case (head_i.code)
                dsd_pkg::OP_BASE: begin
                    produce     = 1'b1;
                    kind_next   = dsd_pkg::KIND_BASE;
                    value_next  = head_i.value;
                    length_next = 24'd0;
                end
                dsd_pkg::OP_TARGET: begin
                    produce          = 1'b1;
                    kind_next        = dsd_pkg::KIND_TARGET;
                    value_next       = head_i.value;
                    length_next      = 24'd0;
                    target_left_next = head_i.value;
                end
                dsd_pkg::OP_COPY: begin
                    produce          = 1'b1;
                    kind_next        = dsd_pkg::KIND_COPY;
                    value_next       = head_i.value;
                    length_next      = copy_clamped;
                    target_left_next = target_left_reg - {8'd0, copy_clamped};
                end
                dsd_pkg::OP_INSERT: begin
                    emit_left_next = emit_clamped;
                end
                dsd_pkg::OP_LIT: begin
                    if (emit_left_reg != 7'd0) begin
                        produce        = 1'b1;
                        kind_next      = dsd_pkg::KIND_LIT;
                        value_next     = {24'd0, head_i.value[7:0]};
                        length_next    = 24'd0;
                        emit_left_next = emit_left_reg - 7'd1;
                        if (target_left_reg != 32'd0) begin
                            target_left_next = target_left_reg - 32'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (head_i.last) begin
                target_left_next = 32'd0;
                emit_left_next   = 7'd0;
            end
        end
        if (produce) begin
            m_valid_next = 1'b1;
        end else if (m_ready_i) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_left_reg <= 32'd0;
            emit_left_reg   <= 7'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            target_left_reg <= target_left_next;
            emit_left_reg   <= emit_left_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (produce) begin
            kind_reg   <= kind_next;
            value_reg  <= value_next;
            length_reg <= length_next;
        end
    end

    assign m_valid_o = m_valid_reg;
    assign kind_o    = kind_reg;
    assign value_o   = value_reg;
    assign length_o  = length_reg;

    `DSD_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid_reg && !m_ready_i,
        m_valid_reg && $stable(kind_reg) && $stable(value_reg) && $stable(length_reg))
    `DSD_ASSERT_SAME(a_noncopy_len_zero, aclk, aresetn,
        m_valid_reg && (kind_reg != dsd_pkg::KIND_COPY), length_reg == 24'd0)
    `DSD_ASSERT_NEXT(a_emit_within_target, aclk, aresetn,
        1'b1, {25'd0, emit_left_reg} <= target_left_reg)

endmodule

>>> rtl/delta_stream_decoder_core.sv
// A completed operation is written into the queue and registered in the back end before m_tvalid.
// One word per cycle while the queue is not full; the back end pops one op a cycle when free.
// A four-entry queue lets the parser keep accepting while a result waits on m_tready.
// Reset: aresetn is synchronous and active low; it empties the queue and returns the
// parser to the base size header with nothing owed.
// ----------------------------------------------------------------------------
// Delta stream decoder core
// Streaming decoder for one delta stream per frame: header sizes, copies and literals.
// ----------------------------------------------------------------------------
module delta_stream_decoder_core #(
    parameter int SIZE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [31:0] value, [55:32] length
    output logic [1:0]  m_tuser    // [1:0] kind
);

    logic          accept;
    logic          push;
    logic          pop;
    logic          queue_full;
    logic          queue_empty;
    dsd_pkg::op_t  op_in;
    dsd_pkg::op_t  op_head;
    logic [1:0]    kind;
    logic [31:0]   value;
    logic [23:0]   length;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    dsd_front #(
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept_i    (accept),
        .data_byte_i (s_tdata),
        .last_i      (s_tlast),
        .push_o      (push),
        .op_o        (op_in)
    );

    dsd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .op_i    (op_in),
        .pop_i   (pop),
        .full_o  (queue_full),
        .empty_o (queue_empty),
        .head_o  (op_head)
    );

    dsd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .empty_i   (queue_empty),
        .head_i    (op_head),
        .pop_o     (pop),
        .m_valid_o (m_tvalid),
        .m_ready_i (m_tready),
        .kind_o    (kind),
        .value_o   (value),
        .length_o  (length)
    );

    assign m_tdata = {length, value};
    assign m_tuser = kind;

endmodule
